### src/gpdc_pkg.sv
// Shared widths, constants and state encodings of the gas dosing PI controller.
`default_nettype none

package gpdc_pkg;

  localparam int READ_W  = 14;
  localparam int OFS_W   = 11;
  localparam int GAIN_W  = 16;
  localparam int CFG_W   = 16;
  localparam int ERR_W   = 16;
  localparam int ACC_W   = 16;
  localparam int INTEG_W = 15;
  localparam int DUTY_W  = 7;
  localparam int PULSE_W = 10;

  localparam int MA_W   = 32;
  localparam int MB_W   = 16;
  localparam int PROD_W = MA_W + MB_W;
  localparam int NUM_W  = PROD_W + 1;
  localparam int DEN_W  = 32;
  localparam int REM_W  = 39;
  localparam int QK_W   = 3;

  localparam int INTEG_LIMIT      = 9999;
  localparam int DUTY_MAX         = 100;
  localparam int ERR_MIN_FOR_DUTY = 6;
  localparam int PTERM_LIMIT      = 100;
  localparam int PULSE_MAX        = 1023;
  localparam int RECIP_100        = 5243;
  localparam int RECIP_SH         = 19;

  typedef enum logic [2:0] {
    REG_SETPOINT,
    REG_HIGH_ALARM,
    REG_LOW_ALARM,
    REG_OFFSET,
    REG_PROP_NUM,
    REG_PROP_DEN,
    REG_INTEG_NUM,
    REG_INTEG_DEN
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_MUL_A,
    S_MUL_B,
    S_MUL_C,
    S_DIV,
    S_DIVW,
    S_PULSE,
    S_OUT
  } ctl_state_t;

  typedef enum logic [1:0] {
    D_IDLE,
    D_CHK,
    D_STEP
  } div_state_t;

endpackage

`default_nettype wire

### src/gpdc_in_if.sv
// Sample channel: valid/ready handshake with the reading and status flags.
`default_nettype none

interface gpdc_in_if;
  import gpdc_pkg::*;

  logic              valid;
  logic              ready;
  logic [READ_W-1:0] reading;
  logic              door_closed;
  logic              sensor_fault;
  logic              tank_one_low;
  logic              tank_two_low;

  modport source (
    output valid, reading, door_closed, sensor_fault, tank_one_low, tank_two_low,
    input  ready
  );

  modport sink (
    input  valid, reading, door_closed, sensor_fault, tank_one_low, tank_two_low,
    output ready
  );
endinterface

`default_nettype wire

### src/gpdc_out_if.sv
// Result channel: valid/ready handshake with duty, pulse, valve and alarm fields.
`default_nettype none

interface gpdc_out_if;
  import gpdc_pkg::*;

  logic               valid;
  logic               ready;
  logic [DUTY_W-1:0]  duty_percent;
  logic [PULSE_W-1:0] pulse_time;
  logic               main_valve_on;
  logic               backup_valve_on;
  logic               setpoint_reached;
  logic               high_alarm;
  logic               low_alarm;

  modport source (
    output valid, duty_percent, pulse_time, main_valve_on, backup_valve_on,
           setpoint_reached, high_alarm, low_alarm,
    input  ready
  );

  modport sink (
    input  valid, duty_percent, pulse_time, main_valve_on, backup_valve_on,
           setpoint_reached, high_alarm, low_alarm,
    output ready
  );
endinterface

`default_nettype wire

### src/gpdc_smul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`default_nettype none

module gpdc_smul #(
  parameter int A_W = 32,
  parameter int B_W = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [A_W-1:0]       a,
  input  wire logic [B_W-1:0]       b,
  output logic                      done,
  output logic [A_W+B_W-1:0]        prod
);
  import gpdc_pkg::*;

  localparam int CNT_W = $clog2(B_W + 1);

  logic [A_W-1:0]     a_r;
  logic [B_W-1:0]     b_r;
  logic [A_W+B_W-1:0] p_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [A_W:0]       sum;

  assign sum  = {1'b0, p_r[A_W+B_W-1:B_W]} + (b_r[0] ? {1'b0, a_r} : '0);
  assign done = done_r;
  assign prod = p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(B_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      p_r <= '0;
    end else if (busy_r) begin
      p_r <= {sum, p_r[B_W-1:1]};
      b_r <= b_r >> 1;
    end
  end

endmodule

`default_nettype wire

### src/gpdc_qdiv.sv
// Restoring divider for the duty quotient, saturated at full scale, one bit per cycle.
`default_nettype none

module gpdc_qdiv (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [gpdc_pkg::PROD_W-1:0]   num,
  input  wire logic [gpdc_pkg::DEN_W-1:0]    den,
  output logic                               done,
  output logic [gpdc_pkg::DUTY_W-1:0]        q
);
  import gpdc_pkg::*;

  div_state_t         st_r, st_nxt;
  logic [PROD_W-1:0]  num_r;
  logic [DEN_W-1:0]   den_r;
  logic [QK_W-1:0]    k_r;
  logic [DUTY_W-1:0]  q_r;
  logic               done_r;
  logic [REM_W-1:0]   den_full;
  logic [REM_W-1:0]   den_sh;
  logic [REM_W:0]     trial;
  logic               at_full;

  assign den_full = REM_W'(den_r) * REM_W'(DUTY_MAX);
  assign at_full  = num_r >= PROD_W'(den_full);
  assign den_sh   = REM_W'(den_r) << k_r;
  assign trial    = {1'b0, num_r[REM_W-1:0]} - {1'b0, den_sh};
  assign done     = done_r;
  assign q        = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= D_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      D_IDLE: begin
        if (start) st_nxt = D_CHK;
      end
      D_CHK: begin
        st_nxt = at_full ? D_IDLE : D_STEP;
      end
      D_STEP: begin
        if (k_r == '0) st_nxt = D_IDLE;
      end
      default: st_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= ((st_r == D_CHK) && at_full) || ((st_r == D_STEP) && (k_r == '0));
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      D_IDLE: begin
        if (start) begin
          num_r <= num;
          den_r <= den;
        end
      end
      D_CHK: begin
        k_r <= QK_W'(DUTY_W - 1);
        q_r <= at_full ? DUTY_W'(DUTY_MAX) : '0;
      end
      D_STEP: begin
        if (!trial[REM_W]) begin
          num_r    <= PROD_W'(trial[REM_W-1:0]);
          q_r[k_r] <= 1'b1;
        end
        k_r <= k_r - 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

### src/gas_pi_dosing_controller.sv
// Top level: gas dosing PI controller with bit-serial multiply and divide.
// The time from input beat to result beat is set by three bit-serial multiply passes and,
// when the quotient is formed, the 7-step restoring quotient loop. One sample is in flight;
// the next is taken once the result sits in the output register.
// Reset (synchronous, rst_n low): registers to their defaults, integrator zero, main tank.
`default_nettype none

module gas_pi_dosing_controller #(
  parameter int PULSE_PERIOD = 1000
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire gpdc_pkg::cfg_idx_t            cfg_idx,
  input  wire logic [gpdc_pkg::CFG_W-1:0]    cfg_data,
  gpdc_in_if.sink                            in_ch,
  gpdc_out_if.source                         out_ch
);
  import gpdc_pkg::*;

  localparam int PQ  = PULSE_PERIOD / 100;
  localparam int PRK = (PULSE_PERIOD % 100) * RECIP_100;
  localparam logic signed [ACC_W-1:0] I_MAX = ACC_W'(INTEG_LIMIT);
  localparam logic signed [ACC_W-1:0] I_MIN = -ACC_W'(INTEG_LIMIT);
  localparam logic signed [ERR_W-1:0] E_MIN = ERR_W'(ERR_MIN_FOR_DUTY);

  // configuration registers
  logic [READ_W-1:0] sp_r, hi_lvl_r, lo_lvl_r;
  logic [OFS_W-1:0]  ofs_r;
  logic [GAIN_W-1:0] pn_r, pd_r, inum_r, id_r;

  // sample and control state
  ctl_state_t               state_r, state_nxt;
  logic signed [ERR_W-1:0]  e_r;
  logic                     ctrl_r, t1_r, t2_r;
  logic                     reached_r, hi_r, lo_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [INTEG_W-1:0] integ_r;
  logic [DEN_W-1:0]         den_r;
  logic [NUM_W-1:0]         num_r;
  logic [DUTY_W-1:0]        duty_r;
  logic [PULSE_W-1:0]       pulse_r;
  logic                     backup_r;

  // output register
  logic                     out_valid_r;
  logic [DUTY_W-1:0]        o_duty_r;
  logic [PULSE_W-1:0]       o_pulse_r;
  logic                     o_main_r, o_back_r, o_reached_r, o_hi_r, o_lo_r;

  // capture logic
  logic signed [ERR_W-1:0]  corr, err;
  logic                     alarms_on, hi_now, in_acc;
  logic [GAIN_W-1:0]        pd_eff, id_eff;

  // multiplier and divider hookup
  logic                     mua_start, mub_start, mua_done, mub_done;
  logic [MA_W-1:0]          mua_a, mub_a;
  logic [MB_W-1:0]          mua_b, mub_b;
  logic [PROD_W-1:0]        mua_p, mub_p;
  logic                     div_start, div_done;
  logic [DUTY_W-1:0]        div_q;

  logic [22:0]              pd_lim;
  logic                     keep_integ;
  logic signed [ACC_W-1:0]  acc_sum, acc_nxt;
  logic [INTEG_W-1:0]       integ_clamped;
  logic [ACC_W-1:0]         acc_neg, acc_mag;
  logic                     num_pos, duty_go, out_load, back_sel;
  logic [16:0]              pul_whole, pul_sum;
  logic [25:0]              pul_frac;
  logic [PULSE_W-1:0]       pul_sat;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign corr      = $signed({2'b00, in_ch.reading}) +
                     $signed({{(ERR_W-OFS_W){ofs_r[OFS_W-1]}}, ofs_r});
  assign err       = $signed({2'b00, sp_r}) - corr;
  assign alarms_on = !in_ch.sensor_fault && (sp_r != '0);
  assign hi_now    = corr >= $signed({2'b00, hi_lvl_r});

  assign pd_eff = (pd_r == '0) ? GAIN_W'(1) : pd_r;
  assign id_eff = (id_r == '0) ? GAIN_W'(1) : id_r;

  assign pd_lim     = 23'(pd_eff) * 23'(PTERM_LIMIT);
  assign keep_integ = e_r[ERR_W-1] || (e_r == '0) || (mua_p < PROD_W'(pd_lim));
  assign acc_sum    = $signed({integ_r[INTEG_W-1], integ_r}) + e_r;
  assign acc_nxt    = keep_integ ? acc_sum : '0;
  assign integ_clamped = (acc_nxt > I_MAX) ? I_MAX[INTEG_W-1:0] :
                         (acc_nxt < I_MIN) ? I_MIN[INTEG_W-1:0] : acc_nxt[INTEG_W-1:0];
  assign acc_neg    = -acc_r;
  assign acc_mag    = acc_r[ACC_W-1] ? acc_neg : acc_r;

  assign num_pos = !num_r[NUM_W-1] && (num_r[NUM_W-2:0] != '0);
  assign duty_go = ctrl_r && (e_r > E_MIN) && num_pos;

  assign pul_whole = 17'(duty_r) * 17'(PQ);
  assign pul_frac  = 26'(duty_r) * 26'(PRK);
  assign pul_sum   = pul_whole + 17'(pul_frac[25:RECIP_SH]);
  assign pul_sat   = (pul_sum > 17'(PULSE_MAX)) ? PULSE_W'(PULSE_MAX) : pul_sum[PULSE_W-1:0];

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);
  assign back_sel = !t2_r && (t1_r || backup_r);

  assign in_ch.ready = (state_r == S_IDLE);

  assign out_ch.valid            = out_valid_r;
  assign out_ch.duty_percent     = o_duty_r;
  assign out_ch.pulse_time       = o_pulse_r;
  assign out_ch.main_valve_on    = o_main_r;
  assign out_ch.backup_valve_on  = o_back_r;
  assign out_ch.setpoint_reached = o_reached_r;
  assign out_ch.high_alarm       = o_hi_r;
  assign out_ch.low_alarm        = o_lo_r;

  gpdc_smul #(.A_W(MA_W), .B_W(MB_W)) u_mul_a (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mua_start),
    .a     (mua_a),
    .b     (mua_b),
    .done  (mua_done),
    .prod  (mua_p)
  );

  gpdc_smul #(.A_W(MA_W), .B_W(MB_W)) u_mul_b (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mub_start),
    .a     (mub_a),
    .b     (mub_b),
    .done  (mub_done),
    .prod  (mub_p)
  );

  gpdc_qdiv u_qdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r[PROD_W-1:0]),
    .den   (den_r),
    .done  (div_done),
    .q     (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    mua_start = 1'b0;
    mub_start = 1'b0;
    mua_a     = '0;
    mua_b     = '0;
    mub_a     = '0;
    mub_b     = '0;
    div_start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) state_nxt = S_PREP;
      end
      S_PREP: begin
        // error times prop gain, and the common denominator
        mua_start = 1'b1;
        mua_a     = e_r[ERR_W-1] ? '0 : MA_W'(e_r[ERR_W-2:0]);
        mua_b     = pn_r;
        mub_start = 1'b1;
        mub_a     = MA_W'(pd_eff);
        mub_b     = id_eff;
        state_nxt = S_MUL_A;
      end
      S_MUL_A: begin
        if (mua_done) begin
          mua_start = 1'b1;
          mua_a     = mua_p[MA_W-1:0];
          mua_b     = id_eff;
          mub_start = 1'b1;
          mub_a     = MA_W'(inum_r);
          mub_b     = pd_eff;
          state_nxt = S_MUL_B;
        end
      end
      S_MUL_B: begin
        if (mua_done) begin
          mub_start = 1'b1;
          mub_a     = mub_p[MA_W-1:0];
          mub_b     = acc_mag;
          state_nxt = S_MUL_C;
        end
      end
      S_MUL_C: begin
        if (mub_done) state_nxt = S_DIV;
      end
      S_DIV: begin
        div_start = duty_go;
        state_nxt = duty_go ? S_DIVW : S_PULSE;
      end
      S_DIVW: begin
        if (div_done) state_nxt = S_PULSE;
      end
      S_PULSE: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r     <= '0;
      hi_lvl_r <= READ_W'(10000);
      lo_lvl_r <= '0;
      ofs_r    <= '0;
      pn_r     <= GAIN_W'(1);
      pd_r     <= GAIN_W'(1);
      inum_r   <= '0;
      id_r     <= GAIN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_SETPOINT:   sp_r     <= cfg_data[READ_W-1:0];
        REG_HIGH_ALARM: hi_lvl_r <= cfg_data[READ_W-1:0];
        REG_LOW_ALARM:  lo_lvl_r <= cfg_data[READ_W-1:0];
        REG_OFFSET:     ofs_r    <= cfg_data[OFS_W-1:0];
        REG_PROP_NUM:   pn_r     <= cfg_data[GAIN_W-1:0];
        REG_PROP_DEN:   pd_r     <= cfg_data[GAIN_W-1:0];
        REG_INTEG_NUM:  inum_r   <= cfg_data[GAIN_W-1:0];
        REG_INTEG_DEN:  id_r     <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r     <= '0;
      backup_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_MUL_A) && mua_done) begin
        integ_r <= ctrl_r ? integ_clamped : '0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        if (pulse_r != '0) backup_r <= back_sel;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      e_r       <= err;
      ctrl_r    <= alarms_on && in_ch.door_closed;
      t1_r      <= in_ch.tank_one_low;
      t2_r      <= in_ch.tank_two_low;
      reached_r <= alarms_on && (corr >= $signed({2'b00, sp_r}));
      hi_r      <= alarms_on && hi_now;
      lo_r      <= alarms_on && !hi_now && (corr <= $signed({2'b00, lo_lvl_r}));
    end
    if ((state_r == S_MUL_A) && mua_done) begin
      acc_r <= acc_nxt;
      den_r <= mub_p[DEN_W-1:0];
    end
    if ((state_r == S_MUL_C) && mub_done) begin
      num_r <= acc_r[ACC_W-1] ? ({1'b0, mua_p} - {1'b0, mub_p})
                              : ({1'b0, mua_p} + {1'b0, mub_p});
    end
    if ((state_r == S_DIV) && !duty_go) begin
      duty_r <= '0;
    end else if ((state_r == S_DIVW) && div_done) begin
      duty_r <= div_q;
    end
    if (state_r == S_PULSE) begin
      pulse_r <= pul_sat;
    end
    if (out_load) begin
      o_duty_r    <= duty_r;
      o_pulse_r   <= pulse_r;
      o_main_r    <= (pulse_r != '0) && !back_sel;
      o_back_r    <= (pulse_r != '0) && back_sel;
      o_reached_r <= reached_r;
      o_hi_r      <= hi_r;
      o_lo_r      <= lo_r;
    end
  end

  a_integ_range: assert property (@(posedge clk) disable iff (!rst_n)
    (integ_r <= I_MAX) && (integ_r >= I_MIN))
    else $error("integrator outside clamp range");

  a_valve_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(o_main_r && o_back_r) && ((o_pulse_r == '0) == !(o_main_r || o_back_r)))
    else $error("valve select inconsistent with pulse");

  a_duty_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (o_duty_r <= DUTY_W'(DUTY_MAX)) && ((o_duty_r != '0) || (o_pulse_r == '0)))
    else $error("duty out of range or pulse without duty");

  a_mul_phase: assert property (@(posedge clk) disable iff (!rst_n)
    mua_done |-> (state_r == S_MUL_A) || (state_r == S_MUL_B))
    else $error("multiplier finished outside its phase");

endmodule

`default_nettype wire
